### rtl/ipfd_pkg.sv
// Shared types, constants and window-compare function for the IR frame decoder.
package ipfd_pkg;

  localparam int DUR_W      = 15;
  localparam int CNT_W      = 8;
  localparam int ADDR_W     = 5;
  localparam int CMD_W      = 7;
  localparam int RAW_W      = 32;
  localparam int ADDR_LSB   = 7;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  localparam logic [DUR_W-1:0] HEADER_MARK_RESET  = 15'd2400;
  localparam logic [DUR_W-1:0] HEADER_SPACE_RESET = 15'd600;
  localparam logic [DUR_W-1:0] ZERO_MARK_RESET    = 15'd600;
  localparam logic [DUR_W-1:0] ONE_MARK_RESET     = 15'd1200;
  localparam logic [DUR_W-1:0] TOLERANCE_RESET    = 15'd200;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_ZERO_MARK    = 3'd2,
    REG_ONE_MARK     = 3'd3,
    REG_TOLERANCE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark_time;
    logic [DUR_W-1:0] header_space_time;
    logic [DUR_W-1:0] zero_mark_time;
    logic [DUR_W-1:0] one_mark_time;
    logic [DUR_W-1:0] match_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [DUR_W-1:0] mark_time;
    logic [DUR_W-1:0] space_time;
    logic             frame_end;
  } symbol_t;

  typedef struct packed {
    logic              frame_valid;
    logic [CNT_W-1:0]  bits_taken;
    logic [ADDR_W-1:0] device_address;
    logic [CMD_W-1:0]  command_code;
    logic [RAW_W-1:0]  raw_word;
  } result_t;

  // strict window: t - tol < v < t + tol, rewritten without a negative bound
  function automatic logic within_window(input logic [DUR_W-1:0] v,
                                         input logic [DUR_W-1:0] t,
                                         input logic [DUR_W-1:0] tol);
    logic [DUR_W:0] v_plus_tol;
    logic [DUR_W:0] t_plus_tol;
    v_plus_tol = {1'b0, v} + {1'b0, tol};
    t_plus_tol = {1'b0, t} + {1'b0, tol};
    return (v_plus_tol > {1'b0, t}) && ({1'b0, v} < t_plus_tol);
  endfunction

endpackage

### rtl/ipfd_if.sv
// Valid/ready channel interfaces for symbol beats and result beats.
interface ipfd_symbol_if;
  import ipfd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] mark_time;
  logic [DUR_W-1:0] space_time;
  logic             frame_end;

  modport source (output valid, output mark_time, output space_time, output frame_end,
                  input ready);
  modport sink (input valid, input mark_time, input space_time, input frame_end,
                output ready);
endinterface

interface ipfd_result_if;
  import ipfd_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_valid;
  logic [CNT_W-1:0]  bits_taken;
  logic [ADDR_W-1:0] device_address;
  logic [CMD_W-1:0]  command_code;
  logic [RAW_W-1:0]  raw_word;

  modport source (output valid, output frame_valid, output bits_taken,
                  output device_address, output command_code, output raw_word,
                  input ready);
  modport sink (input valid, input frame_valid, input bits_taken,
                input device_address, input command_code, input raw_word,
                output ready);
endinterface

### rtl/ipfd_frame_decoder.sv
// Symbol input register, per-frame decode state and result assembly.
module ipfd_frame_decoder #(
  parameter int WORD_BITS   = 32,
  parameter int MIN_SYMBOLS = 13,
  parameter int MIN_BITS    = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  ipfd_pkg::cfg_t    cfg,
  input  logic              sym_accept,
  input  ipfd_pkg::symbol_t sym,
  output logic              push,
  output ipfd_pkg::result_t push_data
);
  import ipfd_pkg::*;

  logic           sym_valid;
  symbol_t        sym_q;

  logic [CNT_W-1:0]     symbol_count, symbol_count_next, upd_count;
  logic                 header_good, header_good_next, upd_header;
  logic                 decode_stopped, decode_stopped_next, upd_stopped;
  logic [CNT_W-1:0]     bit_counter, bit_counter_next, upd_bits;
  logic [WORD_BITS-1:0] shift_word, shift_word_next, upd_word;

  logic is_one;
  logic is_zero;
  logic [RAW_W-1:0] raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else begin
      sym_valid <= sym_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_accept) begin
      sym_q <= sym;
    end
  end

  assign is_one  = within_window(sym_q.mark_time, cfg.one_mark_time, cfg.match_tolerance);
  assign is_zero = within_window(sym_q.mark_time, cfg.zero_mark_time, cfg.match_tolerance);

  always_comb begin
    upd_count   = symbol_count;
    upd_header  = header_good;
    upd_stopped = decode_stopped;
    upd_bits    = bit_counter;
    upd_word    = shift_word;
    if (symbol_count == '0) begin
      upd_header = within_window(sym_q.mark_time, cfg.header_mark_time, cfg.match_tolerance)
                && within_window(sym_q.space_time, cfg.header_space_time,
                                 cfg.match_tolerance);
    end else if (!decode_stopped) begin
      if (is_one || is_zero) begin
        for (int i = 0; i < WORD_BITS; i++) begin
          if (is_one && bit_counter == CNT_W'(i)) begin
            upd_word[i] = 1'b1;
          end
        end
        if (bit_counter != CNT_MAX) begin
          upd_bits = bit_counter + 1'b1;
        end
      end else begin
        upd_stopped = 1'b1;
      end
    end
    if (symbol_count != CNT_MAX) begin
      upd_count = symbol_count + 1'b1;
    end
  end

  assign raw = RAW_W'(upd_word);

  always_comb begin
    push                = sym_valid && sym_q.frame_end;
    push_data.frame_valid = upd_header
                         && (upd_count >= CNT_W'(MIN_SYMBOLS))
                         && (upd_bits >= CNT_W'(MIN_BITS));
    push_data.bits_taken     = upd_bits;
    push_data.device_address = raw[ADDR_LSB +: ADDR_W];
    push_data.command_code   = raw[CMD_W-1:0];
    push_data.raw_word       = raw;

    symbol_count_next   = symbol_count;
    header_good_next    = header_good;
    decode_stopped_next = decode_stopped;
    bit_counter_next    = bit_counter;
    shift_word_next     = shift_word;
    if (sym_valid) begin
      if (sym_q.frame_end) begin
        symbol_count_next   = '0;
        header_good_next    = 1'b0;
        decode_stopped_next = 1'b0;
        bit_counter_next    = '0;
        shift_word_next     = '0;
      end else begin
        symbol_count_next   = upd_count;
        header_good_next    = upd_header;
        decode_stopped_next = upd_stopped;
        bit_counter_next    = upd_bits;
        shift_word_next     = upd_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count   <= '0;
      header_good    <= 1'b0;
      decode_stopped <= 1'b0;
      bit_counter    <= '0;
      shift_word     <= '0;
    end else begin
      symbol_count   <= symbol_count_next;
      header_good    <= header_good_next;
      decode_stopped <= decode_stopped_next;
      bit_counter    <= bit_counter_next;
      shift_word     <= shift_word_next;
    end
  end

endmodule

### rtl/ipfd_result_buffer.sv
// Two-entry result register queue that decouples the decoder from a stalled receiver.
module ipfd_result_buffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ipfd_pkg::result_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output ipfd_pkg::result_t head_data,
  output logic [1:0]        count
);
  import ipfd_pkg::*;

  result_t entry0;
  result_t entry1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b11: begin
        if (count == 2'd2) begin
          entry0 <= entry1;
          entry1 <= push_data;
        end else begin
          entry0 <= push_data;
        end
      end
      2'b01: begin
        entry0 <= entry1;
      end
      2'b10: begin
        if (count == 2'd0) begin
          entry0 <= push_data;
        end else begin
          entry1 <= push_data;
        end
      end
      default: entry0 <= entry0;
    endcase
  end

  assign head_valid = (count != 2'd0);
  assign head_data  = entry0;

endmodule

### rtl/ir_pulse_width_frame_decoder_core.sv
// Top level of the pulse-width IR frame decoder: config registers, decoder, result queue.
//
// Usage:
//   symbol: one beat per IR symbol (mark_time, space_time, frame_end). The first beat of
//           a frame is the header; each mark after it is a one or a zero, or decoding stops.
//   result: one beat per frame, issued for the symbol that carries frame_end.
//   APB:    five 15-bit timing registers at byte addresses 0, 4, 8, 12, 16; write them
//           only while no frame is in progress and the result queue is empty.
// Throughput: one symbol per cycle while symbol.ready is high. The frame state updates
// from the registered symbol, and a result beat is valid once it reaches the result queue.
// A two-entry result queue keeps symbol.ready high while one result waits; symbol.ready
// drops only when both entries, counting a result still in the decode stage, are taken
// and result.ready is low. Results leave in order and stay stable while stalled.
// Reset (rst, synchronous) clears the frame state and the result queue and restores the
// timing registers to 2400/600/600/1200/200 us.
module ir_pulse_width_frame_decoder_core #(
  parameter int WORD_BITS   = 32,
  parameter int MIN_SYMBOLS = 13,
  parameter int MIN_BITS    = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  ipfd_symbol_if.sink                          symbol,
  ipfd_result_if.source                        result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ipfd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ipfd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ipfd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import ipfd_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_index;
  logic                 reg_write;
  logic [DUR_W-1:0]     wdata;

  symbol_t     sym;
  logic        sym_accept;
  logic        push;
  result_t     push_data;
  logic        pop;
  logic        head_valid;
  result_t     head_data;
  logic [1:0]  count;
  logic [2:0]  in_flight;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;
  assign wdata     = pwdata[DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mark_time  <= HEADER_MARK_RESET;
      cfg.header_space_time <= HEADER_SPACE_RESET;
      cfg.zero_mark_time    <= ZERO_MARK_RESET;
      cfg.one_mark_time     <= ONE_MARK_RESET;
      cfg.match_tolerance   <= TOLERANCE_RESET;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_HEADER_MARK:  cfg.header_mark_time  <= wdata;
        REG_HEADER_SPACE: cfg.header_space_time <= wdata;
        REG_ZERO_MARK:    cfg.zero_mark_time    <= wdata;
        REG_ONE_MARK:     cfg.one_mark_time     <= wdata;
        REG_TOLERANCE:    cfg.match_tolerance   <= wdata;
        default:          cfg                   <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_HEADER_MARK:  prdata = APB_DATA_W'(cfg.header_mark_time);
      REG_HEADER_SPACE: prdata = APB_DATA_W'(cfg.header_space_time);
      REG_ZERO_MARK:    prdata = APB_DATA_W'(cfg.zero_mark_time);
      REG_ONE_MARK:     prdata = APB_DATA_W'(cfg.one_mark_time);
      REG_TOLERANCE:    prdata = APB_DATA_W'(cfg.match_tolerance);
      default:          prdata = '0;
    endcase
  end

  assign pop          = head_valid && result.ready;
  assign in_flight    = {1'b0, count} - {2'b00, pop} + {2'b00, push};
  assign symbol.ready = (in_flight < 3'd2);
  assign sym_accept   = symbol.valid && symbol.ready;

  assign sym.mark_time  = symbol.mark_time;
  assign sym.space_time = symbol.space_time;
  assign sym.frame_end  = symbol.frame_end;

  ipfd_frame_decoder #(
    .WORD_BITS   (WORD_BITS),
    .MIN_SYMBOLS (MIN_SYMBOLS),
    .MIN_BITS    (MIN_BITS)
  ) u_decoder (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sym_accept (sym_accept),
    .sym        (sym),
    .push       (push),
    .push_data  (push_data)
  );

  ipfd_result_buffer u_buffer (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (count)
  );

  assign result.valid          = head_valid;
  assign result.frame_valid    = head_data.frame_valid;
  assign result.bits_taken     = head_data.bits_taken;
  assign result.device_address = head_data.device_address;
  assign result.command_code   = head_data.command_code;
  assign result.raw_word       = head_data.raw_word;

endmodule

### rtl/ipfd_checker.sv
// Port-level assertions for the IR frame decoder and their bind to the top level.
module ipfd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        sym_valid,
  input logic                        sym_ready,
  input logic                        frame_end,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        frame_valid,
  input logic [ipfd_pkg::CNT_W-1:0]  bits_taken,
  input logic [ipfd_pkg::RAW_W-1:0]  raw_word
);
  import ipfd_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(frame_valid)
      && $stable(bits_taken) && $stable(raw_word))
    else $error("stalled result beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat valid right after reset");

  a_frame_latency: assert property (@(posedge clk) disable iff (rst)
    sym_valid && sym_ready && frame_end |-> ##2 res_valid)
    else $error("no result beat two cycles after frame end");

  a_valid_has_bits: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_valid |-> bits_taken != '0)
    else $error("valid frame reported with no bits");

endmodule

bind ir_pulse_width_frame_decoder_core ipfd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .sym_valid   (symbol.valid),
  .sym_ready   (symbol.ready),
  .frame_end   (symbol.frame_end),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .frame_valid (result.frame_valid),
  .bits_taken  (result.bits_taken),
  .raw_word    (result.raw_word)
);

### sim/ir_pulse_width_frame_decoder_core_tb.sv
// Testbench for the IR frame decoder: symbol stimulus, APB timing setup and result checks.
module ir_pulse_width_frame_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipfd_pkg::*;

  localparam int FRAME_MIN_SYMBOLS = 13;
  localparam int FRAME_MIN_BITS    = 12;
  localparam int WORD_W            = 32;
  localparam int SYMBOL_BUDGET     = 1700;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ipfd_symbol_if sym ();
  ipfd_result_if res ();

  ir_pulse_width_frame_decoder_core #(
    .WORD_BITS  (WORD_W),
    .MIN_SYMBOLS(FRAME_MIN_SYMBOLS),
    .MIN_BITS   (FRAME_MIN_BITS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .symbol (sym),
    .result (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cfg_t              timing;
  result_t           frame_results_q[$];
  logic [CNT_W-1:0]  frame_symbols;
  logic              header_ok;
  logic              bits_halted;
  logic [CNT_W-1:0]  frame_bits;
  logic [WORD_W-1:0] frame_word;
  int                symbols_sent = 0;
  int                err_count = 0;
  bit                burst_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    res.ready = burst_mode || ($urandom_range(99) >= 30);
  end

  function automatic bit in_window(input logic [DUR_W-1:0] v, input logic [DUR_W-1:0] t,
                                   input logic [DUR_W-1:0] tol);
    int lo;
    int hi;
    lo = int'(t) - int'(tol);
    hi = int'(t) + int'(tol);
    return (int'(v) > lo) && (int'(v) < hi);
  endfunction

  function automatic logic [DUR_W-1:0] near(input logic [DUR_W-1:0] t, input bit edge_ok);
    int span;
    int off;
    int val;
    span = int'(timing.match_tolerance);
    if (span == 0) begin
      off = 0;
    end else begin
      case ($urandom_range(15))
        0: off = edge_ok ? span : span - 1;
        1: off = edge_ok ? -span : 1 - span;
        2: off = span - 1;
        3: off = 1 - span;
        default: off = int'($urandom_range(2 * span - 2)) - (span - 1);
      endcase
    end
    val = int'(t) + off;
    if (val < 0) val = 0;
    if (val > 32767) val = 32767;
    return val[DUR_W-1:0];
  endfunction

  task automatic clear_frame();
    frame_symbols = '0;
    header_ok     = 1'b0;
    bits_halted   = 1'b0;
    frame_bits    = '0;
    frame_word    = '0;
  endtask

  task automatic decode_symbol(input logic [DUR_W-1:0] m, input logic [DUR_W-1:0] s,
                               input logic fe);
    result_t r;
    if (frame_symbols == 0) begin
      header_ok = in_window(m, timing.header_mark_time, timing.match_tolerance) &&
                  in_window(s, timing.header_space_time, timing.match_tolerance);
    end else if (!bits_halted) begin
      if (in_window(m, timing.one_mark_time, timing.match_tolerance)) begin
        if (frame_bits < WORD_W) frame_word[frame_bits[4:0]] = 1'b1;
        if (frame_bits != CNT_MAX) frame_bits++;
      end else if (in_window(m, timing.zero_mark_time, timing.match_tolerance)) begin
        if (frame_bits != CNT_MAX) frame_bits++;
      end else begin
        bits_halted = 1'b1;
      end
    end
    if (frame_symbols != CNT_MAX) frame_symbols++;
    if (fe) begin
      r.frame_valid    = header_ok && (frame_symbols >= FRAME_MIN_SYMBOLS) &&
                         (frame_bits >= FRAME_MIN_BITS);
      r.bits_taken     = frame_bits;
      r.device_address = frame_word[ADDR_LSB +: ADDR_W];
      r.command_code   = frame_word[CMD_W-1:0];
      r.raw_word       = frame_word;
      frame_results_q.push_back(r);
      clear_frame();
    end
  endtask

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    err_count++;
    if (err_count <= 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && res.valid && res.ready) begin
      if (frame_results_q.size() == 0) begin
        flag("unexpected result beat", 32'h0, res.raw_word);
      end else begin
        want = frame_results_q.pop_front();
        if (want.frame_valid !== res.frame_valid)
          flag("frame_valid", want.frame_valid, res.frame_valid);
        if (want.bits_taken !== res.bits_taken)
          flag("bits_taken", want.bits_taken, res.bits_taken);
        if (want.device_address !== res.device_address)
          flag("device_address", want.device_address, res.device_address);
        if (want.command_code !== res.command_code)
          flag("command_code", want.command_code, res.command_code);
        if (want.raw_word !== res.raw_word)
          flag("raw_word", want.raw_word, res.raw_word);
      end
    end
  end

  task automatic send_symbol(input logic [DUR_W-1:0] m, input logic [DUR_W-1:0] s,
                             input logic fe);
    int gap;
    gap = (!burst_mode && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      sym.valid      = 1'b0;
      sym.mark_time  = DUR_W'($urandom);
      sym.space_time = DUR_W'($urandom);
      sym.frame_end  = 1'($urandom);
      @(negedge clk);
    end
    sym.valid      = 1'b1;
    sym.mark_time  = m;
    sym.space_time = s;
    sym.frame_end  = fe;
    do @(posedge clk); while (!sym.ready);
    decode_symbol(m, s, fe);
    symbols_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    sym.valid = 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DUR_W-1:0] v);
    logic [31:0] junk;
    junk    = $urandom;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = {junk[31:DUR_W], v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HEADER_MARK:  timing.header_mark_time  = v;
      REG_HEADER_SPACE: timing.header_space_time = v;
      REG_ZERO_MARK:    timing.zero_mark_time    = v;
      REG_ONE_MARK:     timing.one_mark_time     = v;
      REG_TOLERANCE:    timing.match_tolerance   = v;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(input logic [DUR_W-1:0] hm, input logic [DUR_W-1:0] hs,
                            input logic [DUR_W-1:0] zm, input logic [DUR_W-1:0] om,
                            input logic [DUR_W-1:0] tol);
    drain();
    apb_write(REG_HEADER_MARK, hm);
    apb_write(REG_HEADER_SPACE, hs);
    apb_write(REG_ZERO_MARK, zm);
    apb_write(REG_ONE_MARK, om);
    apb_write(REG_TOLERANCE, tol);
  endtask

  task automatic send_frame(input int n_bits, input int stop_at, input bit bad_header);
    logic [DUR_W-1:0] m;
    logic [DUR_W-1:0] s;
    if (bad_header) begin
      m = $urandom_range(1) ? near(timing.header_mark_time, 1) : DUR_W'($urandom);
      s = near(timing.header_space_time, 1);
    end else begin
      m = near(timing.header_mark_time, 0);
      s = near(timing.header_space_time, 0);
    end
    send_symbol(m, s, n_bits == 0);
    for (int i = 0; i < n_bits; i++) begin
      if (i == stop_at) m = DUR_W'($urandom);
      else m = $urandom_range(1) ? near(timing.one_mark_time, 0) : near(timing.zero_mark_time, 0);
      send_symbol(m, DUR_W'($urandom), i == n_bits - 1);
    end
  endtask

  task automatic send_noise(input int n);
    logic [DUR_W-1:0] m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: m = DUR_W'($urandom);
        1: m = near(timing.one_mark_time, 1);
        2: m = near(timing.zero_mark_time, 1);
        default: m = near(timing.header_mark_time, 1);
      endcase
      send_symbol(m, DUR_W'($urandom), i == n - 1);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return FRAME_MIN_BITS;
    if (r < 80) return $urandom_range(0, 20);
    if (r < 95) return $urandom_range(13, 32);
    return $urandom_range(33, 48);
  endfunction

  task automatic send_random_frame();
    int k;
    int len;
    k   = $urandom_range(99);
    len = pick_len();
    if (k < 70) send_frame(len, -1, 1'b0);
    else if (k < 80) send_frame(len, (len == 0) ? -1 : $urandom_range(0, len - 1), 1'b0);
    else if (k < 88) send_frame(len, -1, 1'b1);
    else send_noise($urandom_range(1, 16));
  endtask

  task automatic test_directed();
    logic [11:0] pattern;
    pattern = 12'b1011_0100_1101;
    send_frame(0, -1, 1'b0);
    send_symbol('0, '0, 1'b1);
    send_symbol('1, '1, 1'b1);
    send_symbol(HEADER_MARK_RESET, HEADER_SPACE_RESET, 1'b0);
    for (int i = 0; i < 12; i++)
      send_symbol(pattern[i] ? ONE_MARK_RESET : ZERO_MARK_RESET, DUR_W'($urandom), i == 11);
    send_symbol(HEADER_MARK_RESET, HEADER_SPACE_RESET, 1'b0);
    send_symbol(ONE_MARK_RESET, '0, 1'b0);
    send_symbol(ZERO_MARK_RESET, '1, 1'b0);
    send_symbol(15'd900, '0, 1'b0);
    send_symbol(ONE_MARK_RESET, '0, 1'b1);
  endtask

  task automatic test_timing_extremes();
    set_timing(15'd2400, 15'd600, 15'd600, 15'd1200, 15'd0);
    repeat (4) send_random_frame();
    set_timing(15'd2400, 15'd600, 15'd600, 15'd1200, 15'd32767);
    repeat (4) send_random_frame();
    set_timing(15'd0, 15'd0, 15'd0, 15'd0, 15'd200);
    repeat (4) send_random_frame();
    set_timing(15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd200);
    repeat (4) send_random_frame();
    set_timing(15'd32767, 15'd0, 15'd1000, 15'd1150, 15'd300);
    repeat (4) send_random_frame();
    set_timing(15'd2400, 15'd600, 15'd1200, 15'd600, 15'd150);
    repeat (4) send_random_frame();
    set_timing(15'd100, 15'd200, 15'd300, 15'd400, 15'd1);
    repeat (4) send_random_frame();
    set_timing(HEADER_MARK_RESET, HEADER_SPACE_RESET, ZERO_MARK_RESET, ONE_MARK_RESET,
               TOLERANCE_RESET);
    apb_write(REG_SPARE_LO, DUR_W'($urandom));
    apb_write(REG_SPARE_HI, DUR_W'($urandom));
    repeat (4) send_random_frame();
  endtask

  task automatic test_long_frames();
    send_frame(36, -1, 1'b0);
    send_frame(270, -1, 1'b0);
    send_frame(40, 34, 1'b0);
  endtask

  task automatic test_burst();
    int start;
    drain();
    burst_mode = 1'b1;
    start = symbols_sent;
    while (symbols_sent - start < 200) send_random_frame();
    burst_mode = 1'b0;
  endtask

  task automatic test_random();
    int frames;
    frames = 0;
    while (symbols_sent < SYMBOL_BUDGET) begin
      if (frames % 20 == 19) begin
        set_timing(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom),
                   ($urandom_range(3) == 0) ? DUR_W'($urandom) : DUR_W'($urandom_range(1, 2000)));
        if ($urandom_range(1)) apb_write(REG_SPARE_LO + 3'($urandom_range(2)), DUR_W'($urandom));
      end
      send_random_frame();
      frames++;
    end
  endtask

  initial begin
    sym.valid      = 1'b0;
    sym.mark_time  = '0;
    sym.space_time = '0;
    sym.frame_end  = 1'b0;
    res.ready      = 1'b0;
    timing.header_mark_time  = HEADER_MARK_RESET;
    timing.header_space_time = HEADER_SPACE_RESET;
    timing.zero_mark_time    = ZERO_MARK_RESET;
    timing.one_mark_time     = ONE_MARK_RESET;
    timing.match_tolerance   = TOLERANCE_RESET;
    clear_frame();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_timing_extremes();
    test_long_frames();
    test_burst();
    test_random();
    sym.valid = 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/ipfd_pkg.sv
rtl/ipfd_if.sv
rtl/ipfd_frame_decoder.sv
rtl/ipfd_result_buffer.sv
rtl/ir_pulse_width_frame_decoder_core.sv
rtl/ipfd_checker.sv
sim/ir_pulse_width_frame_decoder_core_tb.sv
